// File: sv/frt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the fragment reassembly tracker.
package frt_pkg;

	// Field widths of the header and result items
	localparam int unsigned MSG_W    = 32;
	localparam int unsigned SENDER_W = 64;
	localparam int unsigned PART_W   = 8;
	localparam int unsigned PLEN_W   = 10;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned OFFS_W   = 16;
	localparam int unsigned COUNT_W  = 7;

	// Config port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CAP_W      = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_MAX  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STORE_CAP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd2;

	localparam logic [PLEN_W-1:0]   CHUNK_MAX_RST = 10'd250;
	localparam logic [CAP_W-1:0]    STORE_CAP_RST = 16'd32768;
	localparam logic [TIME_W-1:0]   TIMEOUT_RST   = 32'd15000;

	// Header bytes carried in every fragment payload
	localparam logic [PLEN_W-1:0] HDR_BYTES = 10'd6;

	typedef enum logic [3:0] {
		STS_STORED    = 4'd0,
		STS_COMPLETE  = 4'd1,
		STS_DUPLICATE = 4'd2,
		STS_SHORT     = 4'd3,
		STS_BAD_INDEX = 4'd4,
		STS_MISMATCH  = 4'd5,
		STS_OVERFLOW  = 4'd6,
		STS_BAD_CHUNK = 4'd7,
		STS_BAD_LAST  = 4'd8
	} status_t;

	typedef struct packed {
		logic [MSG_W-1:0]    message_id;
		logic [SENDER_W-1:0] sender_id;
		logic [PART_W-1:0]   part_number;
		logic [PART_W-1:0]   part_total;
		logic [PLEN_W-1:0]   payload_length;
		logic [TIME_W-1:0]   now_ms;
	} in_item_t;

	typedef struct packed {
		status_t             status;
		logic                slot_index;
		logic [OFFS_W-1:0]   write_offset;
		logic [PLEN_W-1:0]   chunk_length;
		logic [OFFS_W-1:0]   message_length;
		logic [MSG_W-1:0]    completed_message_id;
	} out_item_t;

endpackage

// File: sv/fragment_reassembly_tracker_top.sv
`timescale 1ns / 1ps
// Fragment reassembly tracker: slot table, checks and completion reporting.
//
// Usage:
//  - Header items enter on item when start is high and busy is low. busy is
//    always low, so one header is taken every clock cycle.
//  - Each accepted item gives exactly one result on result, marked by done
//    for a single cycle. The receiver has no back-pressure; results must be
//    taken when done is high.
//  - An accepted header passes the input register, then the result register,
//    which drives result. Throughput is one item per cycle.
//  - One input register stage, then the slot match, allocation, checks and
//    state update happen in one combinational pass, with the result
//    registered. The slot table updates at the same edge, so the following
//    header already sees it.
//  - Config registers (chunk_max, store_capacity, slot_timeout_ms) are written
//    through cfg_we/cfg_index/cfg_data and take effect at once; write them
//    only while no header is in flight. Out-of-range indexes are ignored.
//  - arst_n clears the slot table, the pipeline and restores config defaults.
module fragment_reassembly_tracker_top #(
	parameter int unsigned SLOTS          = 2,
	parameter int unsigned MAX_PARTS      = 64,
	parameter int unsigned SENDER_ID_BITS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  frt_pkg::in_item_t                 item,
	output logic                              done,
	output frt_pkg::out_item_t                result,
	input  logic                              cfg_we,
	input  logic [frt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [frt_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned PROD_W = frt_pkg::PART_W + frt_pkg::PLEN_W;

	// Config registers
	logic [frt_pkg::PLEN_W-1:0] chunk_max_q;
	logic [frt_pkg::CAP_W-1:0]  store_cap_q;
	logic [frt_pkg::TIME_W-1:0] timeout_q;

	// Slot table
	logic                         slot_valid_q  [SLOTS];
	logic [frt_pkg::MSG_W-1:0]    slot_msg_q    [SLOTS];
	logic [SENDER_ID_BITS-1:0]    slot_sender_q [SLOTS];
	logic [frt_pkg::PART_W-1:0]   slot_total_q  [SLOTS];
	logic [frt_pkg::COUNT_W-1:0]  slot_count_q  [SLOTS];
	logic [frt_pkg::PLEN_W-1:0]   slot_last_q   [SLOTS];
	logic                         slot_has_q    [SLOTS];
	logic [MAX_PARTS-1:0]         slot_bitmap_q [SLOTS];
	logic [frt_pkg::TIME_W-1:0]   slot_touch_q  [SLOTS];

	// Pipeline registers
	logic               vld_s1;
	frt_pkg::in_item_t  in_s1;
	logic               done_s2;
	frt_pkg::out_item_t res_s2;

	// Combinational pass
	logic [SENDER_ID_BITS-1:0]   snd;
	logic                        match_hit;
	logic [SLOT_W-1:0]           match_idx;
	logic                        free_hit;
	logic [SLOT_W-1:0]           free_idx;
	logic [SLOT_W-1:0]           old_idx;
	logic                        fresh;
	logic [SLOT_W-1:0]           sel;
	logic [frt_pkg::PART_W-1:0]  e_total;
	logic [MAX_PARTS-1:0]        e_bitmap;
	logic [frt_pkg::COUNT_W-1:0] e_count;
	logic                        e_has;
	logic [frt_pkg::PLEN_W-1:0]  e_last;
	logic                        is_short;
	logic                        bad_idx;
	logic [frt_pkg::PART_W-1:0]  part_m1;
	logic [frt_pkg::PART_W-1:0]  total_m1;
	logic [PROD_W-1:0]           offset_full;
	logic [PROD_W-1:0]           mlen_prod;
	logic [PROD_W:0]             end_full;
	logic [PROD_W-1:0]           mlen_full;
	logic [frt_pkg::PLEN_W-1:0]  clen;
	logic [MAX_PARTS-1:0]        part_bit;
	logic                        is_last;
	logic                        dup;
	logic                        acc;
	logic                        complete;
	logic [frt_pkg::COUNT_W-1:0] new_count;
	logic                        new_has;
	logic [frt_pkg::PLEN_W-1:0]  new_last;
	logic                        upd;
	frt_pkg::status_t            sts;
	frt_pkg::out_item_t          res_d;

	assign busy   = 1'b0;
	assign done   = done_s2;
	assign result = res_s2;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_max_q <= frt_pkg::CHUNK_MAX_RST;
			store_cap_q <= frt_pkg::STORE_CAP_RST;
			timeout_q   <= frt_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				frt_pkg::CFG_CHUNK_MAX: chunk_max_q <= cfg_data[frt_pkg::PLEN_W-1:0];
				frt_pkg::CFG_STORE_CAP: store_cap_q <= cfg_data[frt_pkg::CAP_W-1:0];
				frt_pkg::CFG_TIMEOUT:   timeout_q   <= cfg_data[frt_pkg::TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			in_s1 <= item;
		end
	end

	// Slot selection: match, then free or timed out, then oldest
	always_comb begin
		snd       = in_s1.sender_id[SENDER_ID_BITS-1:0];
		match_hit = 1'b0;
		match_idx = '0;
		free_hit  = 1'b0;
		free_idx  = '0;
		old_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (slot_valid_q[i] && slot_msg_q[i] == in_s1.message_id &&
					slot_sender_q[i] == snd) begin
				match_hit = 1'b1;
				match_idx = SLOT_W'(i);
			end
			if (!slot_valid_q[i] ||
					(in_s1.now_ms - slot_touch_q[i]) > timeout_q) begin
				free_hit = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
		// wrapping age scan, first oldest wins on ties
		for (int i = 1; i < SLOTS; i++) begin
			if (((slot_touch_q[i] - slot_touch_q[old_idx]) >> (frt_pkg::TIME_W - 1)) != '0) begin
				old_idx = SLOT_W'(i);
			end
		end
		fresh = ~match_hit;
		sel   = match_hit ? match_idx : (free_hit ? free_idx : old_idx);
	end

	// Checks and completion
	always_comb begin
		e_total  = fresh ? in_s1.part_total : slot_total_q[sel];
		e_bitmap = fresh ? '0 : slot_bitmap_q[sel];
		e_count  = fresh ? '0 : slot_count_q[sel];
		e_has    = fresh ? 1'b0 : slot_has_q[sel];
		e_last   = fresh ? '0 : slot_last_q[sel];

		is_short = in_s1.payload_length < frt_pkg::HDR_BYTES;
		bad_idx  = (in_s1.part_number == '0) || (in_s1.part_total == '0) ||
			(in_s1.part_number > in_s1.part_total) ||
			(in_s1.part_number > frt_pkg::PART_W'(MAX_PARTS));

		part_m1     = in_s1.part_number - 8'd1;
		total_m1    = in_s1.part_total - 8'd1;
		offset_full = PROD_W'(part_m1) * PROD_W'(chunk_max_q);
		mlen_prod   = PROD_W'(total_m1) * PROD_W'(chunk_max_q);
		clen        = in_s1.payload_length - frt_pkg::HDR_BYTES;
		end_full    = {1'b0, offset_full} + (PROD_W + 1)'(clen);
		part_bit    = MAX_PARTS'(1) << part_m1;
		is_last     = in_s1.part_number == in_s1.part_total;

		new_count = e_count + 7'd1;
		new_has   = e_has | is_last;
		new_last  = is_last ? clen : e_last;
		complete  = ({1'b0, new_count} >= e_total) && new_has;
		mlen_full = mlen_prod + PROD_W'(new_last);

		dup = 1'b0;
		acc = 1'b0;
		if (e_total != in_s1.part_total) begin
			sts = frt_pkg::STS_MISMATCH;
		end else if (end_full > (PROD_W + 1)'(store_cap_q)) begin
			sts = frt_pkg::STS_OVERFLOW;
		end else if (!is_last && clen != chunk_max_q) begin
			sts = frt_pkg::STS_BAD_CHUNK;
		end else if (is_last && (clen == '0 || clen > chunk_max_q)) begin
			sts = frt_pkg::STS_BAD_LAST;
		end else if ((e_bitmap & part_bit) != '0) begin
			sts = frt_pkg::STS_DUPLICATE;
			dup = 1'b1;
		end else begin
			acc = 1'b1;
			sts = complete ? frt_pkg::STS_COMPLETE : frt_pkg::STS_STORED;
		end

		upd = vld_s1 & ~is_short & ~bad_idx;

		// Result; short and bad-index headers report zeros beside the status
		res_d = '0;
		if (is_short) begin
			res_d.status = frt_pkg::STS_SHORT;
		end else if (bad_idx) begin
			res_d.status = frt_pkg::STS_BAD_INDEX;
		end else begin
			res_d.status       = sts;
			res_d.slot_index   = sel[0];
			res_d.write_offset = offset_full[frt_pkg::OFFS_W-1:0];
			res_d.chunk_length = clen;
			if (acc && complete) begin
				res_d.message_length       = mlen_full[frt_pkg::OFFS_W-1:0];
				res_d.completed_message_id = in_s1.message_id;
			end
		end
	end

	// Slot table update; a new message starts from the cleared e_* view
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_valid_q[i]  <= 1'b0;
				slot_msg_q[i]    <= '0;
				slot_sender_q[i] <= '0;
				slot_total_q[i]  <= '0;
				slot_count_q[i]  <= '0;
				slot_last_q[i]   <= '0;
				slot_has_q[i]    <= 1'b0;
				slot_bitmap_q[i] <= '0;
				slot_touch_q[i]  <= '0;
			end
		end else if (upd) begin
			if (fresh) begin
				slot_msg_q[sel]    <= in_s1.message_id;
				slot_sender_q[sel] <= snd;
				slot_total_q[sel]  <= in_s1.part_total;
			end
			slot_valid_q[sel]  <= ~(acc & complete);
			slot_bitmap_q[sel] <= acc ? (e_bitmap | part_bit) : e_bitmap;
			slot_count_q[sel]  <= acc ? new_count : e_count;
			slot_last_q[sel]   <= acc ? new_last : e_last;
			slot_has_q[sel]    <= acc ? new_has : e_has;
			if (dup | acc) begin
				slot_touch_q[sel] <= in_s1.now_ms;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			res_s2 <= res_d;
		end
	end

endmodule

// File: sv/frt_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the fragment reassembly tracker, with its bind.
module frt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input frt_pkg::out_item_t result
);

	// Every accepted header later gives a result
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted item produced no result");

	// No result without an earlier accepted header
	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without accepted item");

	// Short and bad-index headers carry zero slot, offset and length
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == frt_pkg::STS_SHORT ||
			result.status == frt_pkg::STS_BAD_INDEX)) |->
		(result.slot_index == 1'b0 && result.write_offset == '0 &&
			result.chunk_length == '0))
		else $error("rejected item with nonzero fields");

	// Completion fields only on completion, and a completed message is never empty
	a_complete_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.status == frt_pkg::STS_COMPLETE) ?
			(result.message_length != '0) :
			(result.message_length == '0 && result.completed_message_id == '0)))
		else $error("completion fields inconsistent with status");

endmodule

bind fragment_reassembly_tracker_top frt_checker u_frt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// File: tb/sv/fragment_reassembly_tracker_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the fragment reassembly tracker: header items in, one status per item.
module fragment_reassembly_tracker_top_tb;
	import frt_pkg::*;

	localparam int unsigned NSLOTS         = 2;
	localparam int unsigned MAXP           = 64;
	localparam int unsigned SENDER_BITS    = 64;
	localparam int unsigned ITEM_TARGET    = 1300;
	localparam int unsigned PHASE_LEN      = 150;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES  = 6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef enum int {
		OP_ITEM,
		OP_CFG,
		OP_DRAIN
	} op_kind_e;

	typedef struct {
		op_kind_e              kind;
		in_item_t              hdr;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} tb_op_t;

	// DUT connections
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	in_item_t              item      = '0;
	logic                  done;
	out_item_t             result;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Stimulus and scoreboard bookkeeping
	tb_op_t      pending_ops[$];
	out_item_t   expected_results[$];
	int unsigned n_items      = 0;
	int unsigned n_sent       = 0;
	int unsigned n_results    = 0;
	int unsigned err_count    = 0;
	int unsigned quiet_cycles = 0;
	bit          all_retired  = 1'b0;

	// Generator view of the config it has scheduled, and its own time base
	int unsigned sched_chunk = CHUNK_MAX_RST;
	logic [31:0] sched_idle  = TIMEOUT_RST;
	logic [31:0] clock_ms    = '0;
	in_item_t    lane0[$];
	in_item_t    lane1[$];
	in_item_t    lane2[$];

	// Predictor config and slot table
	bit [PLEN_W-1:0]  chunk_sz   = CHUNK_MAX_RST;
	bit [CAP_W-1:0]   store_cap  = STORE_CAP_RST;
	bit [TIME_W-1:0]  idle_limit = TIMEOUT_RST;
	bit               live       [NSLOTS];
	bit [MSG_W-1:0]   msg_of     [NSLOTS];
	bit [SENDER_W-1:0] src_of    [NSLOTS];
	bit [PART_W-1:0]  parts_of   [NSLOTS];
	bit [COUNT_W-1:0] got_of     [NSLOTS];
	bit [PLEN_W-1:0]  tail_len   [NSLOTS];
	bit               tail_seen  [NSLOTS];
	bit [63:0]        seen_map   [NSLOTS];
	bit [TIME_W-1:0]  last_touch [NSLOTS];

	fragment_reassembly_tracker_top #(
		.SLOTS(NSLOTS),
		.MAX_PARTS(MAXP),
		.SENDER_ID_BITS(SENDER_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Config write as the block sees it: masked to width, unknown index dropped
	function automatic void apply_register_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_CHUNK_MAX: chunk_sz   = data[PLEN_W-1:0];
			CFG_STORE_CAP: store_cap  = data[CAP_W-1:0];
			CFG_TIMEOUT:   idle_limit = data[TIME_W-1:0];
			default: ;
		endcase
	endfunction

	// Expected result of one header item; updates the slot table
	function automatic out_item_t track_fragment(input in_item_t h);
		out_item_t   r;
		int unsigned s;
		bit          matched;
		bit          placed;
		int unsigned offs;
		int unsigned clen;
		int unsigned mlen;
		logic [63:0] pbit;
		logic [31:0] diff;
		r = '0;
		r.status = STS_SHORT;
		if (h.payload_length < HDR_BYTES)
			return r;
		r.status = STS_BAD_INDEX;
		if (h.part_number == 0 || h.part_total == 0 || h.part_number > h.part_total
				|| h.part_number > MAXP)
			return r;

		// exact match on message and sender
		matched = 1'b0;
		s = 0;
		for (int i = 0; i < NSLOTS; i++)
			if (!matched && live[i] && msg_of[i] == h.message_id
					&& src_of[i] == h.sender_id) begin
				s = i;
				matched = 1'b1;
			end
		// otherwise first free or stale slot
		placed = matched;
		for (int i = 0; i < NSLOTS; i++)
			if (!placed && (!live[i] || (h.now_ms - last_touch[i]) > idle_limit)) begin
				s = i;
				placed = 1'b1;
			end
		// otherwise evict the least recently touched one, lower index on a tie
		if (!placed) begin
			s = 0;
			for (int i = 1; i < NSLOTS; i++) begin
				diff = last_touch[i] - last_touch[s];
				if (diff[31])
					s = i;
			end
		end
		if (!matched) begin
			msg_of[s]    = h.message_id;
			src_of[s]    = h.sender_id;
			parts_of[s]  = h.part_total;
			got_of[s]    = '0;
			tail_len[s]  = '0;
			tail_seen[s] = 1'b0;
			seen_map[s]  = '0;
			live[s]      = 1'b1;
		end

		offs = (32'(h.part_number) - 1) * 32'(chunk_sz);
		clen = 32'(h.payload_length) - 32'(HDR_BYTES);
		pbit = 64'd1 << (h.part_number - 8'd1);
		r.slot_index   = 1'(s);
		r.write_offset = 16'(offs);
		r.chunk_length = 10'(clen);

		if (parts_of[s] != h.part_total)
			r.status = STS_MISMATCH;
		else if (offs + clen > 32'(store_cap))
			r.status = STS_OVERFLOW;
		else if (h.part_number < h.part_total && clen != 32'(chunk_sz))
			r.status = STS_BAD_CHUNK;
		else if (h.part_number == h.part_total && (clen == 0 || clen > 32'(chunk_sz)))
			r.status = STS_BAD_LAST;
		else if ((seen_map[s] & pbit) != 0) begin
			last_touch[s] = h.now_ms;
			r.status = STS_DUPLICATE;
		end else begin
			seen_map[s] = seen_map[s] | pbit;
			got_of[s]   = got_of[s] + 1'b1;
			if (h.part_number == h.part_total) begin
				tail_len[s]  = 10'(clen);
				tail_seen[s] = 1'b1;
			end
			last_touch[s] = h.now_ms;
			r.status = STS_STORED;
			// all parts in, last one included: report and free the slot
			if (got_of[s] >= parts_of[s] && tail_seen[s]) begin
				mlen = (32'(parts_of[s]) - 1) * 32'(chunk_sz) + 32'(tail_len[s]);
				r.message_length       = 16'(mlen);
				r.completed_message_id = h.message_id;
				live[s]  = 1'b0;
				r.status = STS_COMPLETE;
			end
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			err_count++;
		end
	endfunction

	// Stimulus builders: everything lands in pending_ops
	task automatic push_frag(input in_item_t h);
		tb_op_t op;
		op.kind = OP_ITEM;
		op.hdr  = h;
		op.idx  = '0;
		op.data = '0;
		pending_ops.push_back(op);
		n_items++;
	endtask

	task automatic push_header(input logic [MSG_W-1:0] msg, input logic [SENDER_W-1:0] snd,
			input logic [PART_W-1:0] part, input logic [PART_W-1:0] total,
			input logic [PLEN_W-1:0] plen, input logic [TIME_W-1:0] now);
		in_item_t h;
		h.message_id     = msg;
		h.sender_id      = snd;
		h.part_number    = part;
		h.part_total     = total;
		h.payload_length = plen;
		h.now_ms         = now;
		push_frag(h);
	endtask

	task automatic push_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		tb_op_t op;
		op.kind = OP_CFG;
		op.hdr  = '0;
		op.idx  = idx;
		op.data = data;
		pending_ops.push_back(op);
		case (idx)
			CFG_CHUNK_MAX: sched_chunk = data[PLEN_W-1:0];
			CFG_TIMEOUT:   sched_idle  = data;
			default: ;
		endcase
	endtask

	// New config for a phase: fixed extremes first, then random settings
	task automatic start_phase(input int unsigned n);
		logic [PLEN_W-1:0] ck;
		logic [CAP_W-1:0]  cap;
		logic [31:0]       tmo;
		case (n)
			0: begin
				ck  = 10'd1;
				cap = 16'hFFFF;
				tmo = 32'hFFFF_FFFF;
			end
			1: begin
				ck  = 10'h3FF;
				cap = 16'd1;
				tmo = 32'd0;
			end
			2: begin
				ck  = 10'd1017;
				cap = 16'hFFFF;
				tmo = 32'd15000;
			end
			3: begin
				ck  = 10'd16;
				cap = 16'd200;
				tmo = 32'd100;
			end
			default: begin
				ck  = ($urandom_range(3) == 0) ? 10'($urandom_range(1023, 1))
					: 10'($urandom_range(300, 1));
				cap = ($urandom_range(3) == 0) ? 16'($urandom_range(4000, 1))
					: 16'($urandom_range(65535, 1));
				tmo = ($urandom_range(2) == 0) ? 32'($urandom_range(2000)) : $urandom;
			end
		endcase
		// upper data bits carry junk; the block keeps only the register width
		push_write(CFG_CHUNK_MAX, ($urandom & 32'hFFFF_FC00) | 32'(ck));
		push_write(CFG_STORE_CAP, ($urandom & 32'hFFFF_0000) | 32'(cap));
		push_write(CFG_TIMEOUT, tmo);
		if (n == 1)
			push_write(CFG_SPARE, $urandom);
	endtask

	// One message's fragments in random order, with some lost, repeated or damaged
	task automatic plan_message(input int unsigned lane);
		in_item_t    f;
		int unsigned total;
		int unsigned tail;
		int unsigned hi;
		int unsigned j;
		int unsigned k;
		int unsigned tmp;
		int unsigned roll;
		int unsigned copies;
		int unsigned order[$];
		logic [31:0] msg;
		logic [63:0] snd;
		msg = ($urandom_range(3) == 0) ? 32'($urandom_range(3)) : $urandom;
		snd = ($urandom_range(3) == 0) ? 64'($urandom_range(3)) : {$urandom, $urandom};
		roll = $urandom_range(99);
		if (roll < 60)
			total = $urandom_range(4, 1);
		else if (roll < 85)
			total = $urandom_range(12, 5);
		else if (roll < 97)
			total = $urandom_range(40, 13);
		else
			total = $urandom_range(64, 41);
		hi   = (sched_chunk > 1017) ? 1017 : sched_chunk;
		tail = $urandom_range(hi, 1);
		for (j = 1; j <= total; j++)
			order.push_back(j);
		for (j = total - 1; j >= 1; j--) begin
			k = $urandom_range(j);
			tmp = order[j];
			order[j] = order[k];
			order[k] = tmp;
		end
		for (j = 0; j < total; j++) begin
			f.message_id     = msg;
			f.sender_id      = snd;
			f.part_number    = 8'(order[j]);
			f.part_total     = 8'(total);
			f.payload_length = 10'(((order[j] == total) ? tail : sched_chunk) + 6);
			f.now_ms         = '0;
			roll = $urandom_range(99);
			if (roll < 4)
				f.payload_length = 10'($urandom_range(1023));
			else if (roll < 7)
				f.part_total = 8'($urandom_range(255));
			else if (roll < 9)
				f.part_number = 8'($urandom_range(255));
			copies = (roll >= 9 && roll < 12) ? 0 : (roll >= 12 && roll < 18) ? 2 : 1;
			repeat (copies) begin
				case (lane)
					0: lane0.push_back(f);
					1: lane1.push_back(f);
					default: lane2.push_back(f);
				endcase
			end
		end
	endtask

	// One to three messages interleaved, stamped with an advancing clock
	task automatic add_group();
		int unsigned lanes;
		int unsigned pick;
		int unsigned roll;
		bit          got;
		in_item_t    f;
		logic [31:0] gap;
		roll  = $urandom_range(99);
		lanes = (roll < 40) ? 1 : (roll < 85) ? 2 : 3;
		plan_message(0);
		if (lanes > 1)
			plan_message(1);
		if (lanes > 2)
			plan_message(2);
		while (lane0.size() + lane1.size() + lane2.size() != 0) begin
			pick = $urandom_range(2);
			got  = 1'b0;
			case (pick)
				0: if (lane0.size() != 0) begin
					f = lane0.pop_front();
					got = 1'b1;
				end
				1: if (lane1.size() != 0) begin
					f = lane1.pop_front();
					got = 1'b1;
				end
				default: if (lane2.size() != 0) begin
					f = lane2.pop_front();
					got = 1'b1;
				end
			endcase
			if (got) begin
				roll = $urandom_range(99);
				if (roll < 94)
					gap = $urandom_range(40);
				else if (roll < 98)
					gap = sched_idle + $urandom_range(50);
				else
					gap = $urandom;
				clock_ms = clock_ms + gap;
				f.now_ms = clock_ms;
				push_frag(f);
				// stray header with every field random
				if ($urandom_range(99) < 2)
					push_header($urandom, {$urandom, $urandom}, 8'($urandom_range(255)),
						8'($urandom_range(255)), 10'($urandom_range(1023)), $urandom);
			end
		end
		// occasionally let the pipe run dry before going on
		if ($urandom_range(99) < 3) begin
			f = '0;
			pending_ops.push_back('{OP_DRAIN, f, '0, '0});
		end
	endtask

	// Stimulus, reset and end of run
	initial begin
		int unsigned phase;
		int unsigned next_phase_at;

		// field extremes, short and bad index
		push_header(32'd1, 64'd1, 8'd1, 8'd1, 10'd0, 32'd0);
		push_header(32'd1, 64'd1, 8'd1, 8'd1, 10'd5, 32'd0);
		push_header(32'd1, 64'd1, 8'd0, 8'd1, 10'd100, 32'd0);
		push_header(32'd1, 64'd1, 8'd1, 8'd0, 10'd100, 32'd0);
		push_header(32'd1, 64'd1, 8'd3, 8'd2, 10'd100, 32'd0);
		push_header(32'd1, 64'd1, 8'd65, 8'd70, 10'd256, 32'd0);
		push_header(32'hFFFF_FFFF, '1, 8'd255, 8'd255, 10'd1023, 32'hFFFF_FFFF);
		// empty and oversized last chunk, then a single-part message completes
		push_header(32'd1, 64'd1, 8'd1, 8'd1, 10'd6, 32'd0);
		push_header(32'd1, 64'd1, 8'd1, 8'd1, 10'd1023, 32'd0);
		push_header(32'd1, 64'd1, 8'd1, 8'd1, 10'd106, 32'd10);
		// stored, duplicate, total mismatch, same id from another sender, bad last and bad middle chunk
		push_header(32'd2, 64'd2, 8'd1, 8'd2, 10'd256, 32'd20);
		push_header(32'd2, 64'd2, 8'd1, 8'd2, 10'd256, 32'd30);
		push_header(32'd2, 64'd2, 8'd2, 8'd3, 10'd50, 32'd30);
		push_header(32'd2, 64'd3, 8'd1, 8'd2, 10'd256, 32'd40);
		push_header(32'd2, 64'd2, 8'd2, 8'd2, 10'd257, 32'd40);
		push_header(32'd2, 64'd2, 8'd1, 8'd2, 10'd100, 32'd40);
		// table full: eviction of the older slot, twice
		push_header(32'd3, 64'd3, 8'd1, 8'd4, 10'd256, 32'd50);
		push_header(32'd2, 64'd2, 8'd2, 8'd2, 10'd106, 32'd60);
		push_header(32'd2, 64'd2, 8'd1, 8'd2, 10'd256, 32'd70);
		// stale slot reuse after the idle limit
		push_header(32'd4, 64'd4, 8'd1, 8'd1, 10'd106, 32'd20000);
		// equal touch times: lower slot is evicted
		push_header(32'd5, 64'd5, 8'd1, 8'd2, 10'd256, 32'd30000);
		push_header(32'd6, 64'd6, 8'd1, 8'd2, 10'd256, 32'd30000);
		push_header(32'd7, 64'd7, 8'd1, 8'd2, 10'd256, 32'd30000);
		push_header(32'd7, 64'd7, 8'd2, 8'd2, 10'd56, 32'd30005);
		// highest part number, top bitmap bit
		push_header(32'd8, 64'd8, 8'd64, 8'd64, 10'd256, 32'd30010);
		push_header(32'hFFFF_FFFF, '1, 8'd1, 8'd1, 10'd256, 32'hFFFF_FFFF);
		clock_ms = 32'd30100;

		// random part, in phases of fixed config
		phase = 0;
		next_phase_at = 0;
		while (n_items < ITEM_TARGET) begin
			if (n_items >= next_phase_at) begin
				start_phase(phase);
				phase++;
				next_phase_at = n_items + PHASE_LEN;
			end
			add_group();
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (!all_retired)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Driver: launches queued items and config writes, predicts on acceptance
	always @(posedge clk) begin
		bit                    taken;
		bit                    hold_off;
		int unsigned           sent_now;
		logic                  nxt_start;
		logic                  nxt_we;
		in_item_t              nxt_item;
		logic [CFG_IDX_W-1:0]  nxt_idx;
		logic [CFG_DATA_W-1:0] nxt_data;
		tb_op_t                op;
		if (arst_n) begin
			taken = start && !busy;
			if (taken)
				expected_results.push_back(track_fragment(item));
			if (cfg_we)
				apply_register_write(cfg_index, cfg_data);
			sent_now  = n_sent + (taken ? 1 : 0);
			nxt_start = start && !taken;
			nxt_item  = item;
			nxt_we    = 1'b0;
			nxt_idx   = cfg_index;
			nxt_data  = cfg_data;
			// random gaps, except over one long stretch of items
			hold_off  = ($urandom_range(99) < 32) && !(sent_now >= 400 && sent_now < 700);
			if (!nxt_start && pending_ops.size() != 0) begin
				op = pending_ops[0];
				case (op.kind)
					OP_ITEM: if (!hold_off) begin
						void'(pending_ops.pop_front());
						nxt_start = 1'b1;
						nxt_item  = op.hdr;
					end
					OP_CFG: if (sent_now == n_results) begin
						void'(pending_ops.pop_front());
						nxt_we   = 1'b1;
						nxt_idx  = op.idx;
						nxt_data = op.data;
					end
					OP_DRAIN: if (sent_now == n_results) begin
						void'(pending_ops.pop_front());
					end
					default: ;
				endcase
			end
			start       <= nxt_start;
			item        <= nxt_item;
			cfg_we      <= nxt_we;
			cfg_index   <= nxt_idx;
			cfg_data    <= nxt_data;
			n_sent      <= sent_now;
			all_retired <= (pending_ops.size() == 0) && !nxt_start && !nxt_we
				&& (sent_now == n_results);
		end
	end

	// Monitor: every strobed result against the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with no item pending: status %0d", result.status);
				err_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", want.status, result.status);
				check_field("slot_index", want.slot_index, result.slot_index);
				check_field("write_offset", want.write_offset, result.write_offset);
				check_field("chunk_length", want.chunk_length, result.chunk_length);
				check_field("message_length", want.message_length, result.message_length);
				check_field("completed_message_id", want.completed_message_id,
					result.completed_message_id);
				n_results <= n_results + 1;
			end
		end
	end

	// Watchdog: too long without any handshake ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

endmodule
